/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included.
`define ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/crc16fc_pkg.sv */
// Types, constants and the CRC byte update shared by the frame codec modules.
package crc16fc_pkg;

   // Frame layout and sizing.
   localparam int HDR_BYTES          = 3;
   localparam int CRC_BYTES          = 2;
   localparam int FRAME_OVERHEAD     = HDR_BYTES + CRC_BYTES;
   localparam int TX_FRAME_BYTES_DEF = 64;
   localparam int QUEUE_DEPTH_DEF    = 4;
   localparam int RX_POS_W           = 9;
   localparam logic [RX_POS_W-1:0] RX_POS_MAX = '1;

   // CRC constants.
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] CRC_INIT_ONES = 16'hffff;

   // Command codes of an input item.
   localparam logic CMD_RX = 1'b0;
   localparam logic CMD_TX = 1'b1;

   // Configuration register indexes.
   localparam logic REG_RX_HEAD = 1'b0;
   localparam logic REG_TX_HEAD = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_RX_BYTE = 2'd0;
   localparam logic [1:0] KIND_VERDICT = 2'd1;
   localparam logic [1:0] KIND_TX_BYTE = 2'd2;
   localparam logic [1:0] KIND_REJECT  = 2'd3;

   // Status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_HEAD = 3'd1;
   localparam logic [2:0] ST_BAD_LEN  = 3'd2;
   localparam logic [2:0] ST_BAD_CRC  = 3'd3;
   localparam logic [2:0] ST_TX_LONG  = 3'd4;

   // Remembered CRC modes.
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_XMODEM = 2'd1;
   localparam logic [1:0] MODE_FALSE  = 2'd2;

   // Result steps of one queued run, emitted lowest bit first.
   localparam int STEP_PAY    = 0;
   localparam int STEP_VERD   = 1;
   localparam int STEP_REJ    = 2;
   localparam int STEP_HEAD   = 3;
   localparam int STEP_CMD    = 4;
   localparam int STEP_LEN    = 5;
   localparam int STEP_DATA   = 6;
   localparam int STEP_CRC_HI = 7;
   localparam int STEP_CRC_LO = 8;
   localparam int STEP_W      = 9;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
      logic       first;
      logic       last;
      logic [7:0] frame_cmd;
      logic [7:0] tx_len;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] rx_command;
      logic [7:0] rx_length;
      logic [2:0] status;
      logic [1:0] crc_kind;
      logic       end_of_run;
   } rsp_type;

   // One run of results, as classified by the front part.
   typedef struct packed {
      logic [STEP_W-1:0] steps;
      logic [7:0]        data_byte;
      logic [7:0]        head_byte;
      logic [7:0]        aux_cmd;
      logic [7:0]        aux_len;
      logic [2:0]        status;
      logic [1:0]        mode_pre;
      logic [1:0]        mode_post;
      logic              init_ones;
      logic              tail_zero;
   } entry_type;

   // CRC16 with polynomial 0x1021, one byte, most significant bit first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_i,
                                              input logic [7:0]  byte_i);
      logic [15:0] c;
      c = crc_i ^ {byte_i, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hdl/crc16_frame_codec_core.sv */
// Top level of the CRC16 frame codec: front part, run queue and back part.
//
// Usage: req_ carries one item per transfer. cmd 0 feeds a received frame byte,
// with last on the final byte; cmd 1 feeds a transmit payload item, with
// first on the item carrying frame_cmd and tx_len and last on the final one.
// rsp_ carries result transfers; end_of_run marks the last result of an item.
// csr_ writes rx_head (index 0) and tx_head (index 1) while the block is idle.
// Throughput: one item per cycle while each item gives at most one result
// and rsp_stall is low. An item with several results holds the single result
// port until it has given them all (up to six for a transmit first item that
// is also last), and the run queue of QUEUE_DEPTH entries absorbs bursts
// before req_stall rises. With the queue and the back part idle, the first
// result of an item is written to the queue, then to the output register that offers it.
// Reset clears all receive, transmit and CRC state, the remembered CRC mode,
// both head registers and the queue; no result is valid after reset.
// When the receiver holds rsp_stall, the result register keeps its value,
// the queue fills, and req_stall is raised once the queue is full.
module crc16_frame_codec_core
   import crc16fc_pkg::*;
#(
   parameter int TX_FRAME_BYTES = TX_FRAME_BYTES_DEF,
   parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic      push, q_full, q_pop, q_not_empty;
   entry_type push_data, q_head;

   // Item acceptance and classification.
   crc16fc_front #(
      .TX_FRAME_BYTES(TX_FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   // Queue of result runs.
   crc16fc_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   // Result sequencing.
   crc16fc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

/* hdl/crc16fc_front.sv */
// Front part: accepts items, tracks receive and transmit state, queues result runs.
module crc16fc_front
   import crc16fc_pkg::*;
#(
   parameter int TX_FRAME_BYTES = TX_FRAME_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  logic      csr_we,
   input  logic      csr_index,
   input  logic [7:0] csr_wdata,
   input  logic      q_full,
   output logic      push,
   output entry_type push_data
);

   localparam logic [8:0] TxLenMax = 9'(TX_FRAME_BYTES - FRAME_OVERHEAD);

   logic [7:0]          rx_head_ff, tx_head_ff;
   logic [RX_POS_W-1:0] pos_ff, pos_in;
   logic [7:0]          head_seen_ff, head_seen_in;
   logic [7:0]          cmd_seen_ff, cmd_seen_in;
   logic [7:0]          len_seen_ff, len_seen_in;
   logic [15:0]         xmodem_ff, xmodem_in;
   logic [15:0]         false_ff, false_in;
   logic [15:0]         recv_ff, recv_in;
   logic [1:0]          mode_ff, mode_in;
   logic                rejected_ff, rejected_in;

   logic                accept;
   logic [RX_POS_W-1:0] region;
   logic                in_region;
   logic [15:0]         xmodem_upd, false_upd;
   logic [2:0]          verdict;
   logic [1:0]          verdict_mode;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Receive byte: capture header fields, update both CRCs, judge on the last byte.
   always_comb begin
      head_seen_in = (pos_ff == 9'd0) ? req_data.data_byte : head_seen_ff;
      cmd_seen_in  = (pos_ff == 9'd1) ? req_data.data_byte : cmd_seen_ff;
      len_seen_in  = (pos_ff == 9'd2) ? req_data.data_byte : len_seen_ff;
      region       = 9'(HDR_BYTES) + {1'b0, len_seen_in};
      in_region    = pos_ff < region;
      xmodem_upd   = crc16_byte(xmodem_ff, req_data.data_byte);
      false_upd    = crc16_byte(false_ff, req_data.data_byte);
      xmodem_in    = in_region ? xmodem_upd : xmodem_ff;
      false_in     = in_region ? false_upd : false_ff;
      recv_in      = {recv_ff[7:0], req_data.data_byte};
      pos_in       = (pos_ff != RX_POS_MAX) ? pos_ff + 9'd1 : pos_ff;

      verdict_mode = mode_ff;
      if (head_seen_in != rx_head_ff) begin
         verdict = ST_BAD_HEAD;
      end else if (pos_in != {1'b0, len_seen_in} + 9'(FRAME_OVERHEAD)) begin
         verdict = ST_BAD_LEN;
      end else if (xmodem_in == recv_in) begin
         verdict      = ST_OK;
         verdict_mode = MODE_XMODEM;
      end else if (false_in == recv_in) begin
         verdict      = ST_OK;
         verdict_mode = MODE_FALSE;
      end else begin
         verdict = ST_BAD_CRC;
      end
   end

   // Classify the item into a run of result steps.
   always_comb begin
      push_data           = '0;
      push_data.data_byte = req_data.data_byte;
      push_data.head_byte = tx_head_ff;
      push_data.mode_pre  = mode_ff;
      push_data.mode_post = mode_ff;
      push_data.tail_zero = (mode_ff == MODE_NONE);
      push_data.init_ones = (mode_ff == MODE_FALSE);
      mode_in             = mode_ff;
      rejected_in         = rejected_ff;

      if (req_data.cmd == CMD_RX) begin
         push_data.steps[STEP_PAY]  = in_region && (pos_ff >= 9'(HDR_BYTES));
         push_data.steps[STEP_VERD] = req_data.last;
         push_data.aux_cmd          = cmd_seen_in;
         push_data.aux_len          = len_seen_in;
         push_data.status           = verdict;
         if (req_data.last) begin
            mode_in             = verdict_mode;
            push_data.mode_post = verdict_mode;
         end
      end else if (req_data.first) begin
         push_data.aux_cmd = req_data.frame_cmd;
         push_data.aux_len = req_data.tx_len;
         if ({1'b0, req_data.tx_len} > TxLenMax) begin
            rejected_in               = 1'b1;
            push_data.steps[STEP_REJ] = 1'b1;
            push_data.status          = ST_TX_LONG;
         end else begin
            rejected_in                  = 1'b0;
            push_data.steps[STEP_HEAD]   = 1'b1;
            push_data.steps[STEP_CMD]    = 1'b1;
            push_data.steps[STEP_LEN]    = 1'b1;
            push_data.steps[STEP_DATA]   = (req_data.tx_len != 8'd0);
            push_data.steps[STEP_CRC_HI] = req_data.last;
            push_data.steps[STEP_CRC_LO] = req_data.last;
         end
      end else if (!rejected_ff) begin
         push_data.steps[STEP_DATA]   = 1'b1;
         push_data.steps[STEP_CRC_HI] = req_data.last;
         push_data.steps[STEP_CRC_LO] = req_data.last;
      end
   end

   assign push = accept && (push_data.steps != '0);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         tx_head_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == REG_RX_HEAD) begin
            rx_head_ff <= csr_wdata;
         end
         if (csr_index == REG_TX_HEAD) begin
            tx_head_ff <= csr_wdata;
         end
      end
   end

   // Receive and transmit state; a verdict returns the receive side to its start.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         head_seen_ff <= '0;
         cmd_seen_ff  <= '0;
         len_seen_ff  <= '0;
         xmodem_ff    <= '0;
         false_ff     <= CRC_INIT_ONES;
         recv_ff      <= '0;
         mode_ff      <= MODE_NONE;
         rejected_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         rejected_ff <= rejected_in;
         if (req_data.cmd == CMD_RX) begin
            if (req_data.last) begin
               pos_ff       <= '0;
               head_seen_ff <= '0;
               cmd_seen_ff  <= '0;
               len_seen_ff  <= '0;
               xmodem_ff    <= '0;
               false_ff     <= CRC_INIT_ONES;
               recv_ff      <= '0;
            end else begin
               pos_ff       <= pos_in;
               head_seen_ff <= head_seen_in;
               cmd_seen_ff  <= cmd_seen_in;
               len_seen_ff  <= len_seen_in;
               xmodem_ff    <= xmodem_in;
               false_ff     <= false_in;
               recv_ff      <= recv_in;
            end
         end
      end
   end

endmodule

/* hdl/crc16fc_fifo.sv */
// Short queue of result runs between the front and back parts.
module crc16fc_fifo
   import crc16fc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head_data
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   entry_type           slot_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/crc16fc_back.sv */
// Back part: steps through queued runs, one result a cycle while rsp_stall is low, and builds the transmit CRC.
module crc16fc_back
   import crc16fc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_not_empty,
   input  entry_type q_head,
   output logic      q_pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   entry_type         cur_ff;
   logic [STEP_W-1:0] mask_ff, mask_in;
   logic [15:0]       acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              advance;
   logic              from_head;
   entry_type         src;
   logic [STEP_W-1:0] src_mask, low, rest;
   logic [15:0]       acc_init, crc_out;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign from_head = (mask_ff == '0);
   assign src       = from_head ? q_head : cur_ff;
   assign src_mask  = from_head ? (q_not_empty ? q_head.steps : '0) : mask_ff;
   assign low       = src_mask & (~src_mask + 1'b1);
   assign rest      = src_mask & ~low;
   assign q_pop     = advance && from_head && q_not_empty;
   assign acc_init  = src.init_ones ? CRC_INIT_ONES : 16'h0000;
   assign crc_out   = src.tail_zero ? 16'h0000 : acc_ff;

   // Build the result of the lowest pending step and advance the CRC.
   always_comb begin
      rsp_data_in            = '0;
      rsp_data_in.crc_kind   = src.mode_post;
      rsp_data_in.end_of_run = (rest == '0);
      rsp_data_in.kind       = KIND_TX_BYTE;
      acc_in                 = acc_ff;
      if (low[STEP_PAY]) begin
         rsp_data_in.kind     = KIND_RX_BYTE;
         rsp_data_in.out_byte = src.data_byte;
         rsp_data_in.crc_kind = src.mode_pre;
      end else if (low[STEP_VERD]) begin
         rsp_data_in.kind       = KIND_VERDICT;
         rsp_data_in.rx_command = src.aux_cmd;
         rsp_data_in.rx_length  = src.aux_len;
         rsp_data_in.status     = src.status;
      end else if (low[STEP_REJ]) begin
         rsp_data_in.kind   = KIND_REJECT;
         rsp_data_in.status = src.status;
      end else if (low[STEP_HEAD]) begin
         rsp_data_in.out_byte = src.head_byte;
         acc_in               = crc16_byte(acc_init, src.head_byte);
      end else if (low[STEP_CMD]) begin
         rsp_data_in.out_byte = src.aux_cmd;
         acc_in               = crc16_byte(acc_ff, src.aux_cmd);
      end else if (low[STEP_LEN]) begin
         rsp_data_in.out_byte = src.aux_len;
         acc_in               = crc16_byte(acc_ff, src.aux_len);
      end else if (low[STEP_DATA]) begin
         rsp_data_in.out_byte = src.data_byte;
         acc_in               = crc16_byte(acc_ff, src.data_byte);
      end else if (low[STEP_CRC_HI]) begin
         rsp_data_in.out_byte = crc_out[15:8];
      end else begin
         rsp_data_in.out_byte = crc_out[7:0];
      end
      rsp_valid_in = (src_mask != '0);
      mask_in      = rest;
   end

   // Step mask, transmit CRC and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         mask_ff      <= mask_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Current run and output payload.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/crc16fc_checker.sv */
// Port-level checks of the frame codec result channel, bound to the top level.
`include "assert_macros.svh"

module crc16fc_checker
   import crc16fc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result stays offered and unchanged.
   `ASSERT_DIS(a_hold_valid, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped under stall")
   `ASSERT_DIS(a_hold_data, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data), "result changed under stall")

   // Verdicts and rejects always close their run.
   `ASSERT_DIS(a_close_run, clock, reset, rsp_valid && (rsp_data.kind == KIND_VERDICT || rsp_data.kind == KIND_REJECT) |-> rsp_data.end_of_run, "verdict or reject not last in run")

   // Byte results carry an ok status.
   `ASSERT_DIS(a_byte_status, clock, reset, rsp_valid && (rsp_data.kind == KIND_RX_BYTE || rsp_data.kind == KIND_TX_BYTE) |-> rsp_data.status == ST_OK, "byte result with nonzero status")

   // No result is offered right after reset.
   `ASSERT_ALL(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind crc16_frame_codec_core crc16fc_checker u_checker (.*);

/* tb/tb_crc16_frame_codec_core.sv */
// Self-checking testbench for the CRC16 frame codec core, with a predictor and random traffic.
`timescale 1ns / 100ps

module tb_crc16_frame_codec_core
   import crc16fc_pkg::*;
();

   localparam int TX_LEN_MAX     = TX_FRAME_BYTES_DEF - FRAME_OVERHEAD;
   localparam int HOLD_CYCLES    = 80;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 4000;

   // Shapes of received frames that the generator can build.
   typedef enum int {
      RX_GOOD_XMODEM,
      RX_GOOD_FALSE,
      RX_BAD_HEAD,
      RX_BAD_CRC,
      RX_SHORT,
      RX_LONG
   } rx_shape_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we    = 1'b0;
   logic       csr_index = REG_RX_HEAD;
   logic [7:0] csr_wdata = 8'h00;

   // Items waiting to be offered and results waiting to arrive.
   req_type item_fifo[$];
   rsp_type expected_rsp[$];

   // Predictor copy of the block state and its head registers.
   logic [7:0]          rx_head_reg  = 8'h00;
   logic [7:0]          tx_head_reg  = 8'h00;
   logic [RX_POS_W-1:0] rx_pos       = '0;
   logic [7:0]          hd_seen      = 8'h00;
   logic [7:0]          cmd_seen     = 8'h00;
   logic [7:0]          len_seen     = 8'h00;
   logic [15:0]         xm_acc       = 16'h0000;
   logic [15:0]         cf_acc       = CRC_INIT_ONES;
   logic [15:0]         rx_last_two  = 16'h0000;
   logic [1:0]          crc_mode     = MODE_NONE;
   logic [15:0]         tx_acc       = 16'h0000;
   logic                tx_skip      = 1'b0;

   int src_idle_pct = 0;
   int snk_idle_pct = 0;
   int items_queued = 0;
   int items_sent   = 0;
   int results_checked = 0;
   int verdict_count   = 0;
   int verdict_ok      = 0;
   int reject_count    = 0;
   int errors          = 0;
   int quiet_cycles    = 0;
   int hold_left       = 0;
   logic hold_go       = 1'b0;
   logic hold_taken    = 1'b0;

   crc16_frame_codec_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Bitwise CRC16 update, polynomial 0x1021, message bits taken MSB first.
   function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[15] ^ b[i];
         crc = {crc[14:0], 1'b0};
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [7:0] b, logic [7:0] rc,
                                       logic [7:0] rl, logic [2:0] st);
      rsp_type r;
      r.kind       = kind;
      r.out_byte   = b;
      r.rx_command = rc;
      r.rx_length  = rl;
      r.status     = st;
      r.crc_kind   = crc_mode;
      r.end_of_run = 1'b0;
      expected_rsp.push_back(r);
   endfunction

   function automatic void tx_emit(logic [7:0] b);
      tx_acc = crc16_update(tx_acc, b);
      push_result(KIND_TX_BYTE, b, 8'h00, 8'h00, ST_OK);
   endfunction

   // Work out the results of one accepted item and queue them in order.
   function automatic void predict_codec(req_type it);
      int          n0;
      int          region;
      logic [2:0]  st;
      logic        send_tail;
      logic [15:0] tail;
      rsp_type     r;
      n0        = expected_rsp.size();
      send_tail = 1'b0;
      if (it.cmd == CMD_RX) begin
         region = HDR_BYTES + int'(len_seen);
         case (rx_pos)
            0: hd_seen = it.data_byte;
            1: cmd_seen = it.data_byte;
            2: begin
               len_seen = it.data_byte;
               region   = HDR_BYTES + int'(it.data_byte);
            end
            default: ;
         endcase
         // Header and payload feed both CRCs; payload bytes are forwarded at once.
         if (int'(rx_pos) < region) begin
            xm_acc = crc16_update(xm_acc, it.data_byte);
            cf_acc = crc16_update(cf_acc, it.data_byte);
            if (int'(rx_pos) >= HDR_BYTES) begin
               push_result(KIND_RX_BYTE, it.data_byte, 8'h00, 8'h00, ST_OK);
            end
         end
         rx_last_two = {rx_last_two[7:0], it.data_byte};
         if (rx_pos != RX_POS_MAX) begin
            rx_pos = rx_pos + 1'b1;
         end
         // Verdict: head first, then total length, then XMODEM before CCITT-FALSE.
         if (it.last) begin
            if (hd_seen != rx_head_reg) begin
               st = ST_BAD_HEAD;
            end else if (int'(rx_pos) != int'(len_seen) + FRAME_OVERHEAD) begin
               st = ST_BAD_LEN;
            end else if (xm_acc == rx_last_two) begin
               crc_mode = MODE_XMODEM;
               st       = ST_OK;
            end else if (cf_acc == rx_last_two) begin
               crc_mode = MODE_FALSE;
               st       = ST_OK;
            end else begin
               st = ST_BAD_CRC;
            end
            push_result(KIND_VERDICT, 8'h00, cmd_seen, len_seen, st);
            verdict_count++;
            if (st == ST_OK) begin
               verdict_ok++;
            end
            rx_pos      = '0;
            hd_seen     = 8'h00;
            cmd_seen    = 8'h00;
            len_seen    = 8'h00;
            xm_acc      = 16'h0000;
            cf_acc      = CRC_INIT_ONES;
            rx_last_two = 16'h0000;
         end
      end else if (it.first) begin
         if (int'(it.tx_len) > TX_LEN_MAX) begin
            tx_skip = 1'b1;
            push_result(KIND_REJECT, 8'h00, 8'h00, 8'h00, ST_TX_LONG);
            reject_count++;
         end else begin
            tx_skip = 1'b0;
            tx_acc  = (crc_mode == MODE_FALSE) ? CRC_INIT_ONES : 16'h0000;
            tx_emit(tx_head_reg);
            tx_emit(it.frame_cmd);
            tx_emit(it.tx_len);
            if (it.tx_len != 8'h00) begin
               tx_emit(it.data_byte);
            end
            send_tail = it.last;
         end
      end else if (!tx_skip) begin
         tx_emit(it.data_byte);
         send_tail = it.last;
      end
      // The appended CRC follows the mode at the last item, zero while none is known.
      if (send_tail) begin
         tail = (crc_mode != MODE_NONE) ? tx_acc : 16'h0000;
         push_result(KIND_TX_BYTE, tail[15:8], 8'h00, 8'h00, ST_OK);
         push_result(KIND_TX_BYTE, tail[7:0], 8'h00, 8'h00, ST_OK);
      end
      if (expected_rsp.size() > n0) begin
         r            = expected_rsp.pop_back();
         r.end_of_run = 1'b1;
         expected_rsp.push_back(r);
      end
   endfunction

   function automatic void check_field(string fname, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
         errors++;
      end
   endfunction

   task automatic add_item(logic c, logic [7:0] d, logic f, logic l, logic [7:0] fc,
                           logic [7:0] ln);
      req_type it;
      it.cmd       = c;
      it.data_byte = d;
      it.first     = f;
      it.last      = l;
      it.frame_cmd = fc;
      it.tx_len    = ln;
      item_fifo.push_back(it);
      items_queued++;
   endtask

   // Build a received frame of the given shape and queue its bytes.
   task automatic queue_rx_frame(logic [7:0] head, int len, rx_shape_type shape, int extra);
      logic [7:0]  fb[$];
      logic [15:0] c;
      int          keep;
      if (shape == RX_BAD_HEAD) begin
         fb.push_back(head ^ 8'($urandom_range(1, 255)));
      end else begin
         fb.push_back(head);
      end
      fb.push_back(8'($urandom));
      fb.push_back(8'(len));
      for (int i = 0; i < len; i++) begin
         fb.push_back(8'($urandom));
      end
      c = (shape == RX_GOOD_FALSE) ? CRC_INIT_ONES : 16'h0000;
      if (shape != RX_GOOD_XMODEM && shape != RX_GOOD_FALSE && $urandom_range(1) == 1) begin
         c = CRC_INIT_ONES;
      end
      foreach (fb[i]) begin
         c = crc16_update(c, fb[i]);
      end
      if (shape == RX_BAD_CRC) begin
         c = c ^ 16'(1 << $urandom_range(15));
      end
      fb.push_back(c[15:8]);
      fb.push_back(c[7:0]);
      if (shape == RX_SHORT) begin
         keep = (extra > 0) ? extra : $urandom_range(1, fb.size() - 1);
         while (fb.size() > keep) begin
            void'(fb.pop_back());
         end
      end
      if (shape == RX_LONG) begin
         keep = (extra > 0) ? extra : $urandom_range(1, 3);
         repeat (keep) fb.push_back(8'($urandom));
      end
      foreach (fb[i]) begin
         add_item(CMD_RX, fb[i], 1'($urandom), i == fb.size() - 1, 8'($urandom),
                  8'($urandom));
      end
   endtask

   // Queue a transmit frame: one first item and nitems - 1 further payload items.
   task automatic queue_tx_frame(logic [7:0] fcmd, logic [7:0] len, int nitems);
      add_item(CMD_TX, 8'($urandom), 1'b1, nitems == 1, fcmd, len);
      for (int i = 1; i < nitems; i++) begin
         add_item(CMD_TX, 8'($urandom), 1'b0, i == nitems - 1, 8'($urandom), 8'($urandom));
         // Items after a reject are dropped by the block and do not count.
         if (int'(len) > TX_LEN_MAX) begin
            items_queued--;
         end
      end
   endtask

   // Mostly well-formed frames with random content, the rest broken frames and noise.
   task automatic random_traffic(int count);
      int start;
      int pick;
      int len;
      start = items_queued;
      while (items_queued - start < count) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            queue_rx_frame(rx_head_reg, len,
                           ($urandom_range(1) == 1) ? RX_GOOD_FALSE : RX_GOOD_XMODEM, 0);
         end else if (pick < 70) begin
            case ($urandom_range(19))
               0: queue_tx_frame(8'($urandom), 8'($urandom_range(TX_LEN_MAX + 1, 255)),
                                 $urandom_range(1, 2));
               1: queue_tx_frame(8'($urandom), 8'(TX_LEN_MAX), $urandom_range(1, 3));
               default: begin
                  len = $urandom_range(0, 6);
                  queue_tx_frame(8'($urandom), 8'(len),
                                 ($urandom_range(4) == 0) ? $urandom_range(1, 4)
                                                          : ((len > 0) ? len : 1));
               end
            endcase
         end else if (pick < 85) begin
            queue_rx_frame(rx_head_reg, $urandom_range(0, 6),
                           rx_shape_type'($urandom_range(RX_BAD_HEAD, RX_LONG)), 0);
         end else begin
            add_item(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                     8'($urandom), 8'($urandom));
         end
      end
   endtask

   // Write both head registers back to back; the block is idle at this point.
   task automatic set_heads(logic [7:0] rxh, logic [7:0] txh);
      @(posedge clock);
      csr_we      <= 1'b1;
      csr_index   <= REG_RX_HEAD;
      csr_wdata   <= rxh;
      rx_head_reg  = rxh;
      @(posedge clock);
      csr_index   <= REG_TX_HEAD;
      csr_wdata   <= txh;
      tx_head_reg  = txh;
      @(posedge clock);
      csr_we      <= 1'b0;
   endtask

   // Wait for every queued item to transfer and every expected result to arrive.
   task automatic wait_idle();
      while (item_fifo.size() > 0 || req_valid || expected_rsp.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Driver: offer the next pending item, hold it while stalled, and predict on transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_codec(req_data);
            items_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (item_fifo.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= item_fifo.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest expectation.
   always @(posedge clock) begin : monitor
      rsp_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               errors++;
            end else begin
               exp_r = expected_rsp.pop_front();
               check_field("kind", 8'(exp_r.kind), 8'(rsp_data.kind));
               check_field("out_byte", exp_r.out_byte, rsp_data.out_byte);
               check_field("rx_command", exp_r.rx_command, rsp_data.rx_command);
               check_field("rx_length", exp_r.rx_length, rsp_data.rx_length);
               check_field("status", 8'(exp_r.status), 8'(rsp_data.status));
               check_field("crc_kind", 8'(exp_r.crc_kind), 8'(rsp_data.crc_kind));
               check_field("end_of_run", 8'(exp_r.end_of_run), 8'(rsp_data.end_of_run));
            end
         end
         // One long hold-off lets the run queue fill and back up the input.
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < snk_idle_pct);
         end
      end
   end

   // Watchdog: end the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                     quiet_cycles, expected_rsp.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: both CRC modes, tx tail before any mode, mode change mid-frame,
      // length boundary and reject, short, bad-CRC and bad-head frames.
      set_heads(8'h3C, 8'hC3);
      src_idle_pct = 30;
      snk_idle_pct = 82;
      add_item(CMD_TX, 8'h81, 1'b0, 1'b1, 8'h00, 8'hFF);
      queue_tx_frame(8'hFF, 8'd1, 1);
      queue_rx_frame(rx_head_reg, 1, RX_GOOD_XMODEM, 0);
      add_item(CMD_TX, 8'h00, 1'b1, 1'b0, 8'h00, 8'(TX_LEN_MAX));
      queue_rx_frame(rx_head_reg, 0, RX_GOOD_FALSE, 0);
      add_item(CMD_TX, 8'hFF, 1'b0, 1'b1, 8'hFF, 8'h00);
      queue_tx_frame(8'h5A, 8'd0, 1);
      queue_rx_frame(rx_head_reg, 3, RX_SHORT, 2);
      queue_tx_frame(8'h11, 8'(TX_LEN_MAX + 1), 2);
      queue_rx_frame(rx_head_reg, 0, RX_BAD_CRC, 0);
      add_item(CMD_RX, ~rx_head_reg, 1'b1, 1'b1, 8'hFF, 8'hFF);
      wait_idle();

      // Random part, phase one: head extremes, receiver stalls often.
      set_heads(8'h00, 8'hFF);
      random_traffic(100);
      wait_idle();

      // Phase two: opposite head extremes, sender idles often.
      set_heads(8'hFF, 8'h00);
      src_idle_pct = 82;
      snk_idle_pct = 30;
      random_traffic(100);
      wait_idle();

      // Phase three: random heads, no idling, one long hold-off and one overlong frame.
      set_heads(8'($urandom), 8'($urandom));
      src_idle_pct = 0;
      snk_idle_pct = 0;
      random_traffic(35);
      hold_go = 1'b1;
      queue_rx_frame(rx_head_reg, 20, RX_LONG, 3);
      random_traffic(35);
      wait_idle();

      $display("Run covered %0d item transfers and %0d checked results over four settings.",
               items_sent, results_checked);
      $display("Receive verdicts: %0d, of which %0d good; transmit rejects: %0d.",
               verdict_count, verdict_ok, reject_count);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/crc16fc_pkg.sv
hdl/crc16fc_front.sv
hdl/crc16fc_fifo.sv
hdl/crc16fc_back.sv
hdl/crc16_frame_codec_core.sv
hdl/crc16fc_checker.sv
tb/tb_crc16_frame_codec_core.sv
